### rtl/core/pea_pkg.sv
`default_nettype none

package pea_pkg;

  localparam int MAX_EDGES = 4;
  localparam int CNT_BITS  = 3;
  localparam int POS_BITS  = 3;

  typedef logic [CNT_BITS-1:0] cnt_t;
  typedef logic [POS_BITS-1:0] pos_t;
  typedef logic [2:0]          mode_t;

  localparam mode_t MODE_TRI    = 3'd0;
  localparam mode_t MODE_STRIP  = 3'd1;
  localparam mode_t MODE_QUAD   = 3'd2;
  localparam mode_t MODE_QSTRIP = 3'd3;
  localparam mode_t MODE_FAN    = 3'd4;

  localparam pos_t POS_MAX = 3'd7;

  localparam logic REQ_VERTEX = 1'b0;
  localparam logic REQ_WRITE  = 1'b1;

  localparam logic CFG_PRIM_MODE    = 1'b0;
  localparam logic CFG_REMAP_ENABLE = 1'b1;

  typedef struct packed {
    logic fire;
    logic start;
  } asm_req_t;

endpackage

`default_nettype wire

### rtl/core/pea_assembler.sv
`default_nettype none

module pea_assembler
  import pea_pkg::*;
#(
  parameter int INDEX_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire mode_t                 mode,
  input  wire asm_req_t              req,
  input  wire logic [INDEX_BITS-1:0] vertex,
  output logic      [INDEX_BITS-1:0] edge_s [MAX_EDGES],
  output logic      [INDEX_BITS-1:0] edge_e [MAX_EDGES],
  output cnt_t                       edge_cnt
);

  pos_t                  pos_r, pos_nxt, pos_cur;
  logic                  par_r, par_cur;
  logic [INDEX_BITS-1:0] h0_r, h1_r, h2_r, anchor_r, anchor_cur;

  always_comb begin
    pos_cur    = req.start ? '0 : pos_r;
    par_cur    = req.start ? 1'b0 : par_r;
    anchor_cur = (pos_cur == '0) ? vertex : anchor_r;
  end

  always_comb begin
    for (int i = 0; i < MAX_EDGES; i++) begin
      edge_s[i] = '0;
      edge_e[i] = '0;
    end
    edge_cnt = '0;
    case (mode)
      MODE_TRI: begin
        if (pos_cur >= pos_t'(2)) begin
          edge_s[0] = h1_r;   edge_e[0] = h2_r;
          edge_s[1] = h2_r;   edge_e[1] = vertex;
          edge_s[2] = h1_r;   edge_e[2] = vertex;
          edge_cnt = cnt_t'(3);
        end
      end
      MODE_STRIP: begin
        if (pos_cur >= pos_t'(2)) begin
          if (par_cur) begin
            edge_s[0] = h1_r;   edge_e[0] = vertex;
            edge_s[1] = vertex; edge_e[1] = h2_r;
            edge_s[2] = h1_r;   edge_e[2] = h2_r;
          end else begin
            edge_s[0] = h1_r;   edge_e[0] = h2_r;
            edge_s[1] = h2_r;   edge_e[1] = vertex;
            edge_s[2] = h1_r;   edge_e[2] = vertex;
          end
          edge_cnt = cnt_t'(3);
        end
      end
      MODE_QUAD: begin
        if (pos_cur >= pos_t'(3)) begin
          edge_s[0] = h0_r;   edge_e[0] = h1_r;
          edge_s[1] = h1_r;   edge_e[1] = h2_r;
          edge_s[2] = h2_r;   edge_e[2] = vertex;
          edge_s[3] = h0_r;   edge_e[3] = vertex;
          edge_cnt = cnt_t'(4);
        end
      end
      MODE_QSTRIP: begin
        if (pos_cur >= pos_t'(3) && par_cur) begin
          edge_s[0] = h0_r;   edge_e[0] = h1_r;
          edge_s[1] = vertex; edge_e[1] = h1_r;
          edge_s[2] = h2_r;   edge_e[2] = vertex;
          edge_s[3] = h0_r;   edge_e[3] = h2_r;
          edge_cnt = cnt_t'(4);
        end
      end
      MODE_FAN: begin
        if (pos_cur >= pos_t'(2)) begin
          edge_s[0] = anchor_cur; edge_e[0] = h2_r;
          edge_s[1] = anchor_cur; edge_e[1] = vertex;
          edge_s[2] = h2_r;       edge_e[2] = vertex;
          edge_cnt = cnt_t'(3);
        end
      end
      default: begin
        edge_cnt = '0;
      end
    endcase
  end

  always_comb begin
    if ((mode == MODE_TRI && pos_cur >= pos_t'(2)) ||
        (mode == MODE_QUAD && pos_cur >= pos_t'(3))) begin
      pos_nxt = '0;
    end else if (pos_cur == POS_MAX) begin
      pos_nxt = POS_MAX;
    end else begin
      pos_nxt = pos_cur + pos_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      par_r    <= 1'b0;
      h0_r     <= '0;
      h1_r     <= '0;
      h2_r     <= '0;
      anchor_r <= '0;
    end else if (req.fire) begin
      pos_r    <= pos_nxt;
      par_r    <= ~par_cur;
      h0_r     <= h1_r;
      h1_r     <= h2_r;
      h2_r     <= vertex;
      anchor_r <= anchor_cur;
    end
  end

endmodule

`default_nettype wire

### rtl/core/primitive_to_edge_assembly_core.sv
`default_nettype none

// Wireframe edge assembly. Each accepted vertex request that completes a
// primitive loads its edges into a four-entry edge buffer, and the buffer
// issues one edge per cycle, while the output is not stalled, through the
// remap table to the output register. An item loads as many edges as it
// has: three for triangles, strips and fans, four for quads and quad strips.
// The next request is accepted in the cycle the last edge of the previous
// one issues. A table write request takes a single buffer entry and is
// applied in order with edge reads, so it only affects edges of later
// requests. A vertex that completes nothing loads nothing into the buffer.
// The first edge of a request is loaded into the edge buffer when the
// request is accepted and is then registered into the output register when
// it issues, and each further edge follows while the output is not stalled.
// The remap table has no reset and no clearing pass; entries must be written
// before remapping reads them.
module primitive_to_edge_assembly_core
  import pea_pkg::*;
#(
  parameter int INDEX_BITS  = 12,
  parameter int REMAP_DEPTH = 4096
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_req_type,
  input  wire logic [INDEX_BITS-1:0] in_vertex_index,
  input  wire logic                  in_start_primitive,
  input  wire logic [INDEX_BITS-1:0] in_remap_value,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic      [INDEX_BITS-1:0] out_edge_start,
  output logic      [INDEX_BITS-1:0] out_edge_end,
  output logic                       out_last_edge,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic                  cfg_index,
  input  wire logic [2:0]            cfg_data
);

  localparam int ADDR_BITS = $clog2(REMAP_DEPTH);

  function automatic logic [ADDR_BITS-1:0] tbl_addr(input logic [INDEX_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[ADDR_BITS-1:0];
  endfunction

  mode_t prim_mode_r;
  logic  remap_en_r;

  logic                  in_fire, issue_go;
  asm_req_t              asm_req;
  logic [INDEX_BITS-1:0] asm_s [MAX_EDGES];
  logic [INDEX_BITS-1:0] asm_e [MAX_EDGES];
  cnt_t                  asm_cnt;

  logic [INDEX_BITS-1:0] buf_s_r [MAX_EDGES];
  logic [INDEX_BITS-1:0] buf_e_r [MAX_EDGES];
  cnt_t                  buf_cnt_r;
  logic                  buf_wr_r;

  logic [INDEX_BITS-1:0] remap_mem [REMAP_DEPTH];
  logic [INDEX_BITS-1:0] rd_s_r, rd_e_r, raw_s_r, raw_e_r;
  logic                  last_r, out_valid_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prim_mode_r <= MODE_TRI;
      remap_en_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PRIM_MODE:    prim_mode_r <= cfg_data;
        CFG_REMAP_ENABLE: remap_en_r  <= cfg_data[0];
        default:          prim_mode_r <= prim_mode_r;
      endcase
    end
  end

  assign issue_go = (buf_cnt_r != '0) && (buf_wr_r || !out_valid_r || out_ready);
  assign in_ready = (buf_cnt_r == '0) || (issue_go && buf_cnt_r == cnt_t'(1));
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    asm_req.fire  = in_fire && (in_req_type == REQ_VERTEX);
    asm_req.start = in_start_primitive;
  end

  pea_assembler #(
    .INDEX_BITS(INDEX_BITS)
  ) u_asm (
    .clk     (clk),
    .rst_n   (rst_n),
    .mode    (prim_mode_r),
    .req     (asm_req),
    .vertex  (in_vertex_index),
    .edge_s  (asm_s),
    .edge_e  (asm_e),
    .edge_cnt(asm_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_cnt_r <= '0;
      buf_wr_r  <= 1'b0;
    end else if (in_fire && in_req_type == REQ_WRITE) begin
      buf_cnt_r <= cnt_t'(1);
      buf_wr_r  <= 1'b1;
    end else if (in_fire) begin
      buf_cnt_r <= asm_cnt;
      buf_wr_r  <= 1'b0;
    end else if (issue_go) begin
      buf_cnt_r <= buf_cnt_r - cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_req_type == REQ_WRITE) begin
      buf_s_r[0] <= in_vertex_index;
      buf_e_r[0] <= in_remap_value;
    end else if (in_fire) begin
      for (int i = 0; i < MAX_EDGES; i++) begin
        buf_s_r[i] <= asm_s[i];
        buf_e_r[i] <= asm_e[i];
      end
    end else if (issue_go) begin
      for (int i = 0; i < MAX_EDGES - 1; i++) begin
        buf_s_r[i] <= buf_s_r[i+1];
        buf_e_r[i] <= buf_e_r[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue_go && buf_wr_r) begin
      remap_mem[tbl_addr(buf_s_r[0])] <= buf_e_r[0];
    end
    if (issue_go && !buf_wr_r) begin
      rd_s_r  <= remap_mem[tbl_addr(buf_s_r[0])];
      rd_e_r  <= remap_mem[tbl_addr(buf_e_r[0])];
      raw_s_r <= buf_s_r[0];
      raw_e_r <= buf_e_r[0];
      last_r  <= (buf_cnt_r == cnt_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (issue_go && !buf_wr_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_start = remap_en_r ? rd_s_r : raw_s_r;
  assign out_edge_end   = remap_en_r ? rd_e_r : raw_e_r;
  assign out_last_edge  = last_r;

`ifndef NO_ASSERTIONS
  a_buf_bound: assert property (@(posedge clk) disable iff (!rst_n)
    buf_cnt_r <= cnt_t'(MAX_EDGES))
    else $error("edge buffer count out of range");

  a_load_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> (buf_cnt_r == '0 || buf_cnt_r == cnt_t'(1)))
    else $error("request loaded over pending edges");

  a_write_single: assert property (@(posedge clk) disable iff (!rst_n)
    (buf_wr_r && buf_cnt_r != '0) |-> buf_cnt_r == cnt_t'(1))
    else $error("table write entry holds more than one slot");

  a_stall_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready && !buf_wr_r && buf_cnt_r != '0) |=> out_valid_r)
    else $error("stalled edge dropped");
`endif

endmodule

`default_nettype wire
